FILE: rtl/core/pacs_pkg.sv
// ----------------------------------------------------------------------------
// pacs_pkg
// Shared types, codes and constants of the power-aware core selector.
// ----------------------------------------------------------------------------
`default_nettype none

package pacs_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] FUNC_ENABLE = 2'd0;
   localparam logic [1:0] FUNC_RING   = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;

   // field widths
   localparam int IDX_W   = 4;
   localparam int DIV_W   = 16;
   localparam int MASK_W  = 12;
   localparam int LEN_W   = 4;
   localparam int ID_W    = 8;

   // cores are grouped in pairs; the mate is found by flipping the lowest index bit
   localparam int CORES_PER_GROUP = 2;

   // query limits
   localparam int              MAX_LIST   = 12;
   localparam logic [ID_W-1:0] EMPTY_SLOT = 8'hFF;

   // score classes, emitted in the order idle group, same, lower, higher
   typedef enum logic [2:0] {
      LVL_NONE       = 3'd0,
      LVL_IDLE_GROUP = 3'd1,  // score 70
      LVL_SAME       = 3'd2,  // score 65
      LVL_LOWER      = 3'd3,  // score 55
      LVL_HIGHER     = 3'd4   // score 40
   } level_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_REPLY = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_PAD   = 5'b10000
   } state_type;

   // write command into the core table
   typedef struct packed {
      logic             set_busy;
      logic             set_div;
      logic [IDX_W-1:0] idx;
      logic             busy_val;
      logic [DIV_W-1:0] div_val;
   } table_wr_type;

   // score class for each step of the emission walk
   function automatic level_type walk_level(input logic [1:0] step);
      level_type lvl;
      case (step)
         2'd0:    lvl = LVL_IDLE_GROUP;
         2'd1:    lvl = LVL_SAME;
         2'd2:    lvl = LVL_LOWER;
         default: lvl = LVL_HIGHER;
      endcase
      return lvl;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/power_aware_core_selector.sv
// ----------------------------------------------------------------------------
// power_aware_core_selector
// Tracks busy state and ring divisor per core and answers selection queries.
// ----------------------------------------------------------------------------
// Enable change and ring request: the reply state registers the answer once
// the output is free. Query: a scan of up to 12 cores (one core per cycle,
// shared scorer), a walk of 4 score classes over them, then up to 12 padding
// slots, each held while the output stalls. One transaction runs at a time.
// Reset (synchronous, active high) clears busy flags, divisors, the minimum
// divisor register and the sequencer; no clearing pass is needed.
`default_nettype none

module power_aware_core_selector
   import pacs_pkg::*;
#(
   parameter int NUM_GROUPS = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: tdata = core_idx[3:0], enable[4], req_div[20:5],
   //          cand_mask[32:21], requested_ring_ratio[48:33], list_length[52:49]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic [1:0]  req_tuser,  // func
   // response: tdata = core_id[7:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tuser,  // status
   output logic             rsp_tlast,
   // configuration: min_ring_divisor
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_wdata
);

   localparam int NUM_CORES = NUM_GROUPS * CORES_PER_GROUP;
   localparam int CIDX_W    = $clog2(NUM_CORES);
   localparam int SCAN_N    = (NUM_CORES < MAX_LIST) ? NUM_CORES : MAX_LIST;
   localparam int SIDX_W    = $clog2(SCAN_N);

   // request fields
   logic [IDX_W-1:0]  f_idx;
   logic              f_en;
   logic [DIV_W-1:0]  f_div;
   logic [MASK_W-1:0] f_mask;
   logic [DIV_W-1:0]  f_ratio;
   logic [LEN_W-1:0]  f_len;
   logic [LEN_W-1:0]  len_sat;

   assign f_idx   = req_tdata[3:0];
   assign f_en    = req_tdata[4];
   assign f_div   = req_tdata[20:5];
   assign f_mask  = req_tdata[32:21];
   assign f_ratio = req_tdata[48:33];
   assign f_len   = req_tdata[52:49];
   assign len_sat = (f_len > LEN_W'(MAX_LIST)) ? LEN_W'(MAX_LIST) : f_len;

   // registers
   state_type         state_ff, state_in;
   logic [DIV_W-1:0]  min_div_ff;
   logic [DIV_W-1:0]  ratio_ff, ratio_in;
   logic [SCAN_N-1:0] mask_ff, mask_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [SIDX_W-1:0] scan_ff, scan_in;
   logic [LEN_W-1:0]  picks_ff, picks_in;
   logic [1:0]        lvl_ff, lvl_in;
   logic [SIDX_W-1:0] walk_ff, walk_in;
   logic [LEN_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;
   level_type         score_ff [SCAN_N];

   logic              score_clr, score_we;
   logic              accept, out_free, idx_hit, busy_at_idx, pick;
   logic              walk_hit, walk_end, last_slot;
   table_wr_type      twr;
   logic [NUM_CORES-1:0] busy_vec;
   logic [CIDX_W-1:0] scan_cidx;
   logic [DIV_W-1:0]  scan_div;
   level_type         scan_level;

   assign accept      = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign idx_hit     = (32'(f_idx) < NUM_CORES);
   assign busy_at_idx = idx_hit && busy_vec[CIDX_W'(f_idx)];

   // core table write on an accepted enable change or a ring request to a busy core
   always_comb begin
      twr          = '0;
      twr.idx      = f_idx;
      twr.busy_val = f_en;
      twr.div_val  = (req_tuser == FUNC_ENABLE) ? min_div_ff : f_div;
      if (accept && req_tuser == FUNC_ENABLE && idx_hit && busy_at_idx != f_en) begin
         twr.set_busy = 1'b1;
         twr.set_div  = 1'b1;
      end
      if (accept && req_tuser == FUNC_RING && busy_at_idx) begin
         twr.set_div = 1'b1;
      end
   end

   pacs_core_table #(
      .NUM_CORES (NUM_CORES)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .wr     (twr),
      .rd_idx (scan_cidx),
      .busy   (busy_vec),
      .rd_div (scan_div)
   );

   // shared scorer, one core per scan cycle
   assign scan_cidx = CIDX_W'(scan_ff);

   pacs_score_unit u_score (
      .cand      (mask_ff[scan_ff]),
      .busy_self (busy_vec[scan_cidx]),
      .busy_mate (busy_vec[scan_cidx ^ CIDX_W'(1)]),
      .ratio     (ratio_ff),
      .div       (scan_div),
      .level     (scan_level)
   );

   assign pick      = (scan_level == LVL_IDLE_GROUP);
   assign walk_hit  = (score_ff[walk_ff] == walk_level(lvl_ff));
   assign walk_end  = (walk_ff == '0) && (lvl_ff == 2'd3);
   assign last_slot = (n_ff == len_ff - LEN_W'(1));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      ratio_in      = ratio_ff;
      mask_in       = mask_ff;
      len_in        = len_ff;
      scan_in       = scan_ff;
      picks_in      = picks_ff;
      lvl_in        = lvl_ff;
      walk_in       = walk_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      score_clr     = 1'b0;
      score_we      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = f_idx;
               if (req_tuser == FUNC_ENABLE) begin
                  status_in = 1'b0;
                  state_in  = ST_REPLY;
               end else if (req_tuser == FUNC_RING) begin
                  status_in = !busy_at_idx;
                  state_in  = ST_REPLY;
               end else if (req_tuser == FUNC_QUERY && len_sat != '0) begin
                  ratio_in  = f_ratio;
                  mask_in   = f_mask[SCAN_N-1:0];
                  len_in    = len_sat;
                  scan_in   = '0;
                  picks_in  = '0;
                  score_clr = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = ID_W'(idx_ff);
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN: begin
            score_we = 1'b1;
            if (pick) begin
               picks_in = picks_ff + LEN_W'(1);
            end
            // stop once the idle-pair picks fill the list or the last core is scored
            if ((pick && picks_ff + LEN_W'(1) == len_ff) ||
                scan_ff == SIDX_W'(SCAN_N - 1)) begin
               lvl_in   = 2'd0;
               walk_in  = SIDX_W'(SCAN_N - 1);
               n_in     = '0;
               state_in = ST_EMIT;
            end else begin
               scan_in = scan_ff + SIDX_W'(1);
            end
         end
         ST_EMIT: begin
            if (!walk_hit || out_free) begin
               if (walk_hit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = ID_W'(walk_ff);
                  rsp_status_in = 1'b0;
                  rsp_last_in   = last_slot;
                  n_in          = n_ff + LEN_W'(1);
               end
               if (walk_hit && last_slot) begin
                  state_in = ST_IDLE;
               end else if (walk_end) begin
                  state_in = ST_PAD;
               end else if (walk_ff == '0) begin
                  lvl_in  = lvl_ff + 2'd1;
                  walk_in = SIDX_W'(SCAN_N - 1);
               end else begin
                  walk_in = walk_ff - SIDX_W'(1);
               end
            end
         end
         ST_PAD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = EMPTY_SLOT;
               rsp_status_in = 1'b0;
               rsp_last_in   = last_slot;
               n_in          = n_ff + LEN_W'(1);
               if (last_slot) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         min_div_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            min_div_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ratio_ff      <= ratio_in;
      mask_ff       <= mask_in;
      len_ff        <= len_in;
      scan_ff       <= scan_in;
      picks_ff      <= picks_in;
      lvl_ff        <= lvl_in;
      walk_ff       <= walk_in;
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // score store: cleared at query start, one entry written per scan cycle
   always_ff @(posedge clock) begin
      if (score_clr) begin
         for (int i = 0; i < SCAN_N; i++) begin
            score_ff[i] <= LVL_NONE;
         end
      end else if (score_we) begin
         score_ff[scan_ff] <= scan_level;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/pacs_core_table.sv
// ----------------------------------------------------------------------------
// pacs_core_table
// Per-core busy flags and ring divisors, one write port, one divisor read.
// ----------------------------------------------------------------------------
`default_nettype none

module pacs_core_table
   import pacs_pkg::*;
#(
   parameter int NUM_CORES = 12,
   localparam int CIDX_W   = $clog2(NUM_CORES)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire table_wr_type      wr,
   input  wire logic [CIDX_W-1:0] rd_idx,
   output logic [NUM_CORES-1:0]   busy,
   output logic [DIV_W-1:0]       rd_div
);

   logic [NUM_CORES-1:0] busy_ff;
   logic [DIV_W-1:0]     div_ff [NUM_CORES];
   logic [CIDX_W-1:0]    widx;

   assign widx = CIDX_W'(wr.idx);

   // flag and divisor update; range is checked by the caller
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         for (int i = 0; i < NUM_CORES; i++) begin
            div_ff[i] <= '0;
         end
      end else begin
         if (wr.set_busy) begin
            busy_ff[widx] <= wr.busy_val;
         end
         if (wr.set_div) begin
            div_ff[widx] <= wr.div_val;
         end
      end
   end

   assign busy   = busy_ff;
   assign rd_div = div_ff[rd_idx];

endmodule

`default_nettype wire

FILE: rtl/core/pacs_score_unit.sv
// ----------------------------------------------------------------------------
// pacs_score_unit
// Shared scorer: classifies one candidate core per cycle during a scan.
// ----------------------------------------------------------------------------
`default_nettype none

module pacs_score_unit
   import pacs_pkg::*;
(
   input  wire logic             cand,
   input  wire logic             busy_self,
   input  wire logic             busy_mate,
   input  wire logic [DIV_W-1:0] ratio,
   input  wire logic [DIV_W-1:0] div,
   output level_type             level
);

   // idle pair first, then idle core in busy pair by ratio compare
   always_comb begin
      if (!cand || busy_self) begin
         level = LVL_NONE;
      end else if (!busy_mate) begin
         level = LVL_IDLE_GROUP;
      end else if (ratio == div) begin
         level = LVL_SAME;
      end else if (ratio > div) begin
         level = LVL_HIGHER;
      end else begin
         level = LVL_LOWER;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/pacs_checker.sv
// ----------------------------------------------------------------------------
// pacs_checker
// Port-level checks of the core selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pacs_checker
   import pacs_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   // a stalled response keeps its core id and last flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // an accepted single-answer transaction takes away the input ready
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == FUNC_ENABLE || req_tuser == FUNC_RING)
      |=> !req_tready)
      else $error("input taken while an answer is pending");

   // a rejection is always a single, final answer
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("rejection not marked last");

   // mid-list, no new transaction is accepted
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken in the middle of a list");

endmodule

bind power_aware_core_selector pacs_checker u_pacs_checker (.*);

`default_nettype wire

FILE: tb/core_selection_checker.sv
// ----------------------------------------------------------------------------
// core_selection_checker
// Watches the request, response and register channels of the core selector,
// keeps its own copy of the busy flags and ring divisors, works out the picks
// each request should produce and compares every response transaction with
// the oldest pick still awaited.
// ----------------------------------------------------------------------------
`default_nettype none

module core_selection_checker
   import pacs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [15:0] csr_wdata,
   output int               pending,
   output int               fail_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CORES       = 12;
   localparam int CORES_PER_GROUP = 2;

   typedef struct packed {
      logic [ID_W-1:0] core_id;
      logic            status;
      logic            last;
   } core_pick_type;

   core_pick_type          awaited_picks[$];
   logic [NUM_CORES-1:0]   busy_flags;
   logic [DIV_W-1:0]       ring_div[NUM_CORES];
   logic [DIV_W-1:0]       min_div;
   int                     mismatches;

   initial begin
      pending    = 0;
      fail_count = 0;
      mismatches = 0;
   end

   function automatic logic pair_busy(input int core);
      int base;
      logic any;
      base = (core / CORES_PER_GROUP) * CORES_PER_GROUP;
      any  = 1'b0;
      for (int k = 0; k < CORES_PER_GROUP; k++) any |= busy_flags[base + k];
      return any;
   endfunction

   // Updates the core table for one request and queues the picks it causes
   task automatic forecast_selection(input logic [1:0] func, input logic [55:0] data);
      logic [IDX_W-1:0]  idx;
      logic              en;
      logic [DIV_W-1:0]  div;
      logic [MASK_W-1:0] mask;
      logic [DIV_W-1:0]  ratio;
      int                len;
      int                picks;
      int                n;
      logic              stopped;
      level_type         score[NUM_CORES];
      level_type         lvl;
      idx   = data[3:0];
      en    = data[4];
      div   = data[20:5];
      mask  = data[32:21];
      ratio = data[48:33];
      len   = int'(data[52:49]);
      case (func)
         FUNC_ENABLE: begin
            if (idx < NUM_CORES && busy_flags[idx] != en) begin
               busy_flags[idx] = en;
               ring_div[idx]   = min_div;
            end
            awaited_picks.push_back('{core_id: ID_W'(idx), status: 1'b0, last: 1'b1});
         end
         FUNC_RING: begin
            if (idx < NUM_CORES && busy_flags[idx]) begin
               ring_div[idx] = div;
               awaited_picks.push_back('{core_id: ID_W'(idx), status: 1'b0, last: 1'b1});
            end else begin
               awaited_picks.push_back('{core_id: ID_W'(idx), status: 1'b1, last: 1'b1});
            end
         end
         FUNC_QUERY: begin
            if (len > MAX_LIST) len = MAX_LIST;
            if (len != 0) begin
               // scoring scan, stopping once the idle-pair picks fill the list
               picks   = 0;
               stopped = 1'b0;
               for (int i = 0; i < NUM_CORES; i++) begin
                  score[i] = LVL_NONE;
                  if (!stopped) begin
                     if (mask[i]) begin
                        if (!pair_busy(i)) begin
                           score[i] = LVL_IDLE_GROUP;
                           picks++;
                        end else if (!busy_flags[i]) begin
                           if (ratio == ring_div[i])     score[i] = LVL_SAME;
                           else if (ratio > ring_div[i]) score[i] = LVL_HIGHER;
                           else                          score[i] = LVL_LOWER;
                        end
                     end
                     if (picks == len) stopped = 1'b1;
                  end
               end
               // best class first, higher index first within a class
               n = 0;
               for (int s = 0; s < 4; s++) begin
                  case (s)
                     0:       lvl = LVL_IDLE_GROUP;
                     1:       lvl = LVL_SAME;
                     2:       lvl = LVL_LOWER;
                     default: lvl = LVL_HIGHER;
                  endcase
                  for (int c = NUM_CORES - 1; c >= 0; c--) begin
                     if (score[c] == lvl && n < len) begin
                        awaited_picks.push_back('{core_id: ID_W'(c), status: 1'b0, last: 1'b0});
                        n++;
                     end
                  end
               end
               for (int k = n; k < len; k++)
                  awaited_picks.push_back('{core_id: EMPTY_SLOT, status: 1'b0, last: 1'b0});
               awaited_picks[awaited_picks.size() - 1].last = 1'b1;
            end
         end
         default: begin
            // unused function code: no response
         end
      endcase
   endtask

   task automatic note_failure(input core_pick_type want, input logic have_want);
      fail_count <= fail_count + 1;
      mismatches++;
      if (mismatches <= 10) begin
         if (have_want)
            $display("%0t mismatch: expected core %0d status %0b last %0b, got core %0d status %0b last %0b",
                     $realtime, want.core_id, want.status, want.last,
                     rsp_tdata, rsp_tuser, rsp_tlast);
         else
            $display("%0t unexpected response: core %0d status %0b last %0b",
                     $realtime, rsp_tdata, rsp_tuser, rsp_tlast);
      end
   endtask

   // Channel monitor: responses first, since they always belong to older requests
   always @(posedge clock) begin
      core_pick_type want;
      if (reset) begin
         awaited_picks.delete();
         busy_flags = '0;
         min_div    = '0;
         for (int i = 0; i < NUM_CORES; i++) ring_div[i] = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_picks.size() == 0) begin
               note_failure('0, 1'b0);
            end else begin
               want = awaited_picks.pop_front();
               if (rsp_tdata !== want.core_id || rsp_tuser !== want.status
                   || rsp_tlast !== want.last)
                  note_failure(want, 1'b1);
            end
         end
         if (csr_valid && csr_ready) min_div = csr_wdata;
         if (req_tvalid && req_tready) forecast_selection(req_tuser, req_tdata);
      end
      pending <= awaited_picks.size();
   end

endmodule

`default_nettype wire

FILE: tb/power_aware_core_selector_test.sv
// ----------------------------------------------------------------------------
// power_aware_core_selector_test
// Drives enable changes, ring requests and selection queries into the core
// selector under several minimum-divisor settings, with random gaps and
// output stalls, and lets the checker compare every response.
// ----------------------------------------------------------------------------
`default_nettype none

module power_aware_core_selector_test;

   import pacs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         HOLD_CYCLES = 300;
   localparam int         SETTLE      = 80;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = FUNC_ENABLE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata  = '0;

   int          pending;
   int          fail_count;
   bit          pace_gaps  = 1'b1;
   bit          rsp_hold   = 1'b0;
   logic [15:0] div_hint   = '0;

   power_aware_core_selector i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   core_selection_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .fail_count (fail_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("power_aware_core_selector_test failed");
      $finish;
   end

   function automatic logic [55:0] pack_req(input logic [3:0] idx, input logic en,
                                            input logic [15:0] div, input logic [11:0] mask,
                                            input logic [15:0] ratio, input logic [3:0] len);
      return {3'b000, len, ratio, mask, div, en, idx};
   endfunction

   // One request transaction, with an optional gap before it
   task automatic send_req(input logic [1:0] func, input logic [55:0] data);
      int gap;
      gap = pace_gaps ? $urandom_range(0, 13) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   // Register write once the block has gone quiet
   task automatic write_min_div(input logic [15:0] value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random transaction; returns 0 for the ignored function code
   task automatic random_item(output bit counted);
      int          kind;
      logic [3:0]  idx;
      logic [15:0] val;
      logic [11:0] mask;
      logic [3:0]  len;
      logic        en;
      kind = $urandom_range(0, 99);
      idx  = 4'($urandom_range(0, 11));
      if ($urandom_range(0, 15) == 0) idx = 4'($urandom_range(12, 15));
      val  = ($urandom_range(0, 2) == 0) ? div_hint : 16'($urandom);
      mask = 12'($urandom);
      if ($urandom_range(0, 4) == 0) mask = 12'hFFF;
      len  = 4'($urandom_range(1, 12));
      if ($urandom_range(0, 9) == 0) len = 4'($urandom_range(0, 15));
      en   = 1'($urandom_range(0, 1));
      counted = 1'b1;
      if (kind < 35) begin
         send_req(FUNC_ENABLE, pack_req(idx, en, 16'($urandom), mask, val, len));
      end else if (kind < 60) begin
         send_req(FUNC_RING, pack_req(idx, en, val, mask, 16'($urandom), len));
         div_hint = val;
      end else if (kind < 96) begin
         send_req(FUNC_QUERY, pack_req(idx, en, 16'($urandom), mask, val, len));
      end else begin
         send_req(FUNC_UNUSED, pack_req(idx, en, 16'($urandom), mask, val, len));
         counted = 1'b0;
      end
   endtask

   // Response side: random stall per transaction, plus the long hold-off
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = pace_gaps ? $urandom_range(0, 13) : 0;
         if (rsp_hold) begin
            rsp_hold = 1'b0;
            stall += HOLD_CYCLES;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      logic [15:0] settings[4];
      int          counted_items;
      bit          counted;
      settings[0] = 16'hFFFF;
      settings[1] = 16'h0000;
      settings[2] = 16'($urandom);
      settings[3] = 16'h0001;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      write_min_div(16'h4000);
      div_hint = 16'h4000;
      send_req(FUNC_QUERY,  pack_req(4'd0, 1'b0, 16'h0000, 12'hFFF, 16'h0000, 4'd12));
      send_req(FUNC_QUERY,  pack_req(4'd0, 1'b0, 16'h0000, 12'hFFF, 16'hFFFF, 4'd15));
      send_req(FUNC_QUERY,  pack_req(4'd0, 1'b0, 16'h0000, 12'hFFF, 16'h0000, 4'd0));
      send_req(FUNC_UNUSED, pack_req(4'd5, 1'b1, 16'hFFFF, 12'hFFF, 16'hFFFF, 4'd15));
      send_req(FUNC_ENABLE, pack_req(4'd3, 1'b1, 16'hFFFF, 12'h000, 16'h0000, 4'd0));
      send_req(FUNC_ENABLE, pack_req(4'd3, 1'b1, 16'h0000, 12'h000, 16'h0000, 4'd0));
      send_req(FUNC_RING,   pack_req(4'd3, 1'b0, 16'h1234, 12'h000, 16'h0000, 4'd0));
      send_req(FUNC_RING,   pack_req(4'd2, 1'b0, 16'hFFFF, 12'h000, 16'h0000, 4'd0));
      send_req(FUNC_RING,   pack_req(4'd15, 1'b1, 16'h0001, 12'h000, 16'h0000, 4'd0));
      send_req(FUNC_ENABLE, pack_req(4'd12, 1'b1, 16'h0000, 12'h000, 16'h0000, 4'd0));
      send_req(FUNC_ENABLE, pack_req(4'd14, 1'b1, 16'h0000, 12'h000, 16'h0000, 4'd0));
      send_req(FUNC_ENABLE, pack_req(4'd5, 1'b1, 16'h0000, 12'h000, 16'h0000, 4'd0));
      send_req(FUNC_ENABLE, pack_req(4'd2, 1'b1, 16'h0000, 12'h000, 16'h0000, 4'd0));
      send_req(FUNC_ENABLE, pack_req(4'd2, 1'b0, 16'h0000, 12'h000, 16'h0000, 4'd0));
      send_req(FUNC_RING,   pack_req(4'd5, 1'b1, 16'hFFFF, 12'h000, 16'h0000, 4'd0));
      // idle core 2 holds the minimum, idle core 4 still its reset divisor
      send_req(FUNC_QUERY,  pack_req(4'd0, 1'b0, 16'h0000, 12'hFFF, 16'h4000, 4'd12));
      send_req(FUNC_QUERY,  pack_req(4'd0, 1'b0, 16'h0000, 12'hFFF, 16'h0000, 4'd12));
      send_req(FUNC_QUERY,  pack_req(4'd0, 1'b0, 16'h0000, 12'hFFF, 16'hFFFF, 4'd12));
      send_req(FUNC_QUERY,  pack_req(4'd0, 1'b0, 16'h0000, 12'hFFF, 16'h3FFF, 4'd3));
      send_req(FUNC_QUERY,  pack_req(4'd0, 1'b0, 16'h0000, 12'h000, 16'h0000, 4'd5));
      send_req(FUNC_QUERY,  pack_req(4'd0, 1'b0, 16'h0000, 12'hA5C, 16'h1234, 4'd1));

      // random phases, one of them without idling and one with the hold-off
      for (int p = 0; p < 4; p++) begin
         write_min_div(settings[p]);
         pace_gaps = (p != 1);
         if (p == 2) rsp_hold = 1'b1;
         counted_items = 0;
         while (counted_items < 25) begin
            random_item(counted);
            if (counted) counted_items++;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("power_aware_core_selector_test passed");
      end else begin
         $display("power_aware_core_selector_test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/pacs_pkg.sv
rtl/core/pacs_core_table.sv
rtl/core/pacs_score_unit.sv
rtl/core/power_aware_core_selector.sv
rtl/core/pacs_checker.sv
tb/core_selection_checker.sv
tb/power_aware_core_selector_test.sv
